/* rtl/colormap_interpolating_lookup_top_macros.svh */
// assertion macros for the colormap interpolating lookup
`ifndef COLORMAP_INTERPOLATING_LOOKUP_TOP_MACROS_SVH
`define COLORMAP_INTERPOLATING_LOOKUP_TOP_MACROS_SVH

// checked only outside reset
`define CIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CIL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/cil_pkg.sv */
// shared types and constants of the colormap interpolating lookup
`default_nettype none

package cil_pkg;

  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned APB_AW     = 1;
  localparam int unsigned APB_DW     = 32;

  localparam logic              CMD_WRITE  = 1'b0;
  localparam logic              CMD_LOOKUP = 1'b1;
  localparam logic [APB_AW-1:0] REG_ENTRIES_USED = 1'b0;
  localparam logic [CFG_W-1:0]  ENTRIES_RESET    = 9'd256;

  typedef struct packed {
    logic                  command;
    logic [IDX_W-1:0]      entry_index;
    logic [CHAN_W-1:0]     entry_red;
    logic [CHAN_W-1:0]     entry_green;
    logic [CHAN_W-1:0]     entry_blue;
    logic [LEVEL_BITS-1:0] level;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] frac;
    rgb_t                  lo;
    rgb_t                  hi;
  } blend_in_t;

endpackage

`default_nettype wire

/* rtl/cil_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module cil_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/cil_cfg.sv */
// apb register block holding the palette size, with clamping
`default_nettype none

module cil_cfg #(
  parameter int unsigned PALETTE_DEPTH = 256,
  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cil_pkg::APB_AW-1:0]  paddr,
  input  wire logic [cil_pkg::APB_DW-1:0]  pwdata,
  output logic      [cil_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [AW-1:0]               span_o
);

  logic [cil_pkg::CFG_W-1:0] entries_q, entries_d;
  logic [31:0]               entries_clamped;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == cil_pkg::REG_ENTRIES_USED);

  always_comb begin
    entries_d = entries_q;
    if (wr_en) begin
      entries_d = pwdata[cil_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= cil_pkg::ENTRIES_RESET;
    end else begin
      entries_q <= entries_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == cil_pkg::REG_ENTRIES_USED) begin
      prdata = cil_pkg::APB_DW'(entries_q);
    end
  end

  // effective entry count kept within two and the store depth
  always_comb begin
    if (32'(entries_q) < 32'd2) begin
      entries_clamped = 32'd2;
    end else if (32'(entries_q) > 32'(PALETTE_DEPTH)) begin
      entries_clamped = 32'(PALETTE_DEPTH);
    end else begin
      entries_clamped = 32'(entries_q);
    end
  end

  assign span_o = AW'(entries_clamped - 32'd1);

endmodule

`default_nettype wire

/* rtl/cil_blend.sv */
// two stage per-channel linear blend between neighboring palette entries
`default_nettype none

module cil_blend (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cil_pkg::blend_in_t  in_i,
  output logic                     res_valid_o,
  output cil_pkg::out_word_t       res_word_o
);

  localparam int unsigned LB     = cil_pkg::LEVEL_BITS;
  localparam int unsigned CW     = cil_pkg::CHAN_W;
  localparam int unsigned PROD_W = LB + 1 + CW + 1;

  logic [2:0][CW-1:0]               lo_ch, hi_ch;
  logic signed [2:0][PROD_W-1:0]    prod_d, prod_q;
  logic [2:0][CW-1:0]               base_q;
  logic                             mul_valid_q;
  logic [2:0][CW-1:0]               res_ch_d;
  logic signed [PROD_W-1:0]         sum [3];
  logic                             res_valid_q;
  cil_pkg::out_word_t               res_word_q;

  assign lo_ch = in_i.lo;
  assign hi_ch = in_i.hi;

  // signed step times fraction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = $signed(PROD_W'(in_i.frac))
                * ($signed(PROD_W'(hi_ch[c])) - $signed(PROD_W'(lo_ch[c])));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    base_q <= lo_ch;
  end

  // sum stays non-negative and below one channel step above the base
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]      = $signed({2'b00, base_q[c], LB'(0)}) + prod_q[c];
      res_ch_d[c] = sum[c][LB+CW-1:LB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_word_q <= res_ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= in_i.valid;
      res_valid_q <= mul_valid_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_word_q;

endmodule

`default_nettype wire

/* rtl/colormap_interpolating_lookup_top.sv */
// top level of the colormap interpolating lookup pipeline
//
// usage
//   palette writes and level lookups enter on one command channel: a word is
//   taken at each rising edge with start high and busy low. busy is always
//   low, so one word can enter in every cycle, writes and lookups mixed.
//   a write loads one palette entry and gives no result; a lookup gives one
//   result word on res_word_o, marked by res_valid_o for exactly one cycle.
//   a lookup taken at an edge passes five register stages (input, index
//   multiply, palette read, channel multiply, sum) before its result is on
//   the result ports. throughput: one word per cycle, two palette copies
//   serve both neighbor reads at once.
//   writes reach the palette in the same stage where lookups read it, so
//   every lookup sees exactly the writes taken before it.
//   the receiver cannot stall; results are never held back.
//   the palette size register sits on the apb port; change it only while no
//   lookup is in flight.
//   reset clears all valid bits and sets the palette size to 256; palette
//   contents are undefined until written, and no lookup may read an entry
//   that was never written.
`default_nettype none

`include "colormap_interpolating_lookup_top_macros.svh"

module colormap_interpolating_lookup_top #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire cil_pkg::in_word_t           in_word_i,
  output logic                             res_valid_o,
  output cil_pkg::out_word_t               res_word_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cil_pkg::APB_AW-1:0]  paddr,
  input  wire logic [cil_pkg::APB_DW-1:0]  pwdata,
  output logic      [cil_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned LB = cil_pkg::LEVEL_BITS;
  localparam int unsigned PW = LB + AW;

  logic                  accept;
  logic [AW-1:0]         span;

  logic                  s1_valid_q;
  logic                  s1_cmd_q;
  logic [cil_pkg::IDX_W-1:0] s1_idx_q;
  cil_pkg::rgb_t         s1_rgb_q;
  logic [LB-1:0]         s1_level_q;
  logic [AW-1:0]         s1_span_q;

  logic [PW-1:0]         scaled;
  logic                  s2_valid_q;
  logic                  s2_cmd_q;
  logic [cil_pkg::IDX_W-1:0] s2_idx_q;
  cil_pkg::rgb_t         s2_rgb_q;
  logic [AW-1:0]         s2_pos_q;
  logic [LB-1:0]         s2_frac_q;

  logic                  pal_we;
  logic [AW-1:0]         pos_next;
  cil_pkg::rgb_t         lo_rdata, hi_rdata;

  logic                  s3_valid_q;
  logic [LB-1:0]         s3_frac_q;
  cil_pkg::blend_in_t    blend_in;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cil_cfg #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .span_o  (span)
  );

  // input stage
  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= in_word_i.command;
    s1_idx_q   <= in_word_i.entry_index;
    s1_rgb_q   <= '{red: in_word_i.entry_red, green: in_word_i.entry_green,
                    blue: in_word_i.entry_blue};
    s1_level_q <= in_word_i.level;
    s1_span_q  <= span;
  end

  // level times span: integer part picks the entry pair
  assign scaled = PW'(s1_level_q) * PW'(s1_span_q);

  always_ff @(posedge clk_i) begin
    s2_cmd_q  <= s1_cmd_q;
    s2_idx_q  <= s1_idx_q;
    s2_rgb_q  <= s1_rgb_q;
    s2_pos_q  <= scaled[PW-1:LB];
    s2_frac_q <= scaled[LB-1:0];
  end

  // palette stage: writes and reads share this slot to keep order
  assign pal_we   = s2_valid_q && (s2_cmd_q == cil_pkg::CMD_WRITE)
                    && (32'(s2_idx_q) < 32'(PALETTE_DEPTH));
  assign pos_next = s2_pos_q + AW'(1);

  cil_ram #(
    .WIDTH ($bits(cil_pkg::rgb_t)),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (AW'(s2_idx_q)),
    .wdata_i (s2_rgb_q),
    .raddr_i (s2_pos_q),
    .rdata_o (lo_rdata)
  );

  cil_ram #(
    .WIDTH ($bits(cil_pkg::rgb_t)),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (AW'(s2_idx_q)),
    .wdata_i (s2_rgb_q),
    .raddr_i (pos_next),
    .rdata_o (hi_rdata)
  );

  always_ff @(posedge clk_i) begin
    s3_frac_q <= s2_frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && (s2_cmd_q == cil_pkg::CMD_LOOKUP);
    end
  end

  assign blend_in = '{valid: s3_valid_q, frac: s3_frac_q, lo: lo_rdata, hi: hi_rdata};

  cil_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (blend_in),
    .res_valid_o (res_valid_o),
    .res_word_o  (res_word_o)
  );

  `CIL_ASSERT(a_lookup_gives_result,
    (accept && in_word_i.command == cil_pkg::CMD_LOOKUP) |-> ##5 res_valid_o,
    "lookup word did not produce a result after five cycles")

  `CIL_ASSERT(a_write_gives_none,
    (accept && in_word_i.command == cil_pkg::CMD_WRITE) |-> ##5 !res_valid_o,
    "palette write produced a result word")

  `CIL_ASSERT_ALWAYS(a_reset_quiet,
    !rst_ni |=> !res_valid_o,
    "result strobe right after reset")

endmodule

`default_nettype wire
